FILE: rtl/sbr_pkg.sv
// Shared types and constants for the SBUS frame receiver.
package sbr_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int FRAME_BYTES  = 25;

    localparam int DATA_BYTES = FRAME_BYTES - 3;
    localparam int PAYLOAD_W  = DATA_BYTES * 8;
    localparam int VAL_W      = 11;
    localparam int IDX_W      = 4;
    localparam int CH_W       = $clog2(NUM_CHANNELS);
    localparam int POS_W      = $clog2(FRAME_BYTES + 1);
    localparam int STORE_AW   = $clog2(FRAME_BYTES);
    localparam bit UNPACK_OK  = (NUM_CHANNELS * VAL_W) <= PAYLOAD_W;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_HEADER   = 3'd0,
        REG_FOOTER   = 3'd1,
        REG_GAP      = 3'd2,
        REG_LOST     = 3'd3,
        REG_FAILSAFE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_READY = 2'd2,
        ST_ERROR = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  chan_index;
        logic [VAL_W-1:0]  chan_value;
        logic              lost;
        logic              failsafe;
        logic              last;
        logic [31:0]       timeouts_seen;
        logic [31:0]       malformed_seen;
        logic [31:0]       received_seen;
        logic [31:0]       valid_seen;
    } result_t;

    typedef struct packed {
        logic [31:0] timeouts;
        logic [31:0] malformed;
        logic [31:0] received;
        logic [31:0] valid;
    } ctr_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        status_t              status;
        logic                 lost;
        logic                 failsafe;
        ctr_t                 ctr;
        logic [PAYLOAD_W-1:0] data;
    } entry_t;

endpackage

FILE: rtl/sbr_front.sv
// Front end: gap timeout, frame assembly, counters and classification of each byte.
module sbr_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  sbr_pkg::item_t              item,
    input  logic                        cfg_wr,
    input  logic [sbr_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [sbr_pkg::CFG_DW-1:0]  cfg_data,
    output sbr_pkg::entry_t             entry
);

    logic [7:0]  header_reg;
    logic [7:0]  footer_reg;
    logic [15:0] gap_limit_reg;
    logic [7:0]  lost_mask_reg;
    logic [7:0]  failsafe_mask_reg;

    logic                       in_frame_reg, in_frame_next;
    logic [sbr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]                last_ms_reg, last_ms_next;
    sbr_pkg::ctr_t              ctr_reg, ctr_next;
    logic [7:0]                 store_reg [sbr_pkg::FRAME_BYTES];

    logic                       timeout;
    logic                       active;
    logic                       write_en;
    logic                       write_header;
    logic [sbr_pkg::POS_W-1:0]  pos_inc;
    logic [31:0]                gap;
    logic [7:0]                 flags;
    logic [sbr_pkg::PAYLOAD_W-1:0] data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg        <= 8'h0F;
            footer_reg        <= 8'h00;
            gap_limit_reg     <= 16'd3;
            lost_mask_reg     <= 8'h04;
            failsafe_mask_reg <= 8'h08;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                sbr_pkg::REG_HEADER:   header_reg        <= cfg_data[7:0];
                sbr_pkg::REG_FOOTER:   footer_reg        <= cfg_data[7:0];
                sbr_pkg::REG_GAP:      gap_limit_reg     <= cfg_data;
                sbr_pkg::REG_LOST:     lost_mask_reg     <= cfg_data[7:0];
                sbr_pkg::REG_FAILSAFE: failsafe_mask_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < sbr_pkg::DATA_BYTES; i++)
        begin
            data[8*i +: 8] = store_reg[i + 1];
        end
    end

    assign flags   = store_reg[sbr_pkg::FRAME_BYTES - 2];
    assign gap     = item.time_ms - last_ms_reg;
    assign timeout = in_frame_reg && (gap >= 32'(gap_limit_reg));
    assign active  = in_frame_reg && !timeout;
    assign pos_inc = pos_reg + 1'b1;

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        pos_next         = pos_reg;
        last_ms_next     = last_ms_reg;
        ctr_next         = ctr_reg;
        write_en         = 1'b0;
        write_header     = 1'b0;
        entry.status     = sbr_pkg::ST_IDLE;
        entry.lost       = 1'b0;
        entry.failsafe   = 1'b0;
        entry.data       = data;

        if (timeout)
        begin
            ctr_next.timeouts = ctr_reg.timeouts + 32'd1;
        end

        if (!active)
        begin
            in_frame_next = 1'b0;
            pos_next      = '0;
            last_ms_next  = '0;
            if (item.rx_byte == header_reg)
            begin
                in_frame_next = 1'b1;
                pos_next      = sbr_pkg::POS_W'(1);
                last_ms_next  = item.time_ms;
                write_header  = 1'b1;
                entry.status  = sbr_pkg::ST_BUSY;
            end
        end
        else if (pos_reg >= sbr_pkg::POS_W'(sbr_pkg::FRAME_BYTES))
        begin
            ctr_next.malformed = ctr_reg.malformed + 32'd1;
            in_frame_next      = 1'b0;
            pos_next           = '0;
            last_ms_next       = '0;
            entry.status       = sbr_pkg::ST_ERROR;
        end
        else
        begin
            write_en     = 1'b1;
            pos_next     = pos_inc;
            last_ms_next = item.time_ms;
            entry.status = sbr_pkg::ST_BUSY;
            if (pos_inc >= sbr_pkg::POS_W'(sbr_pkg::FRAME_BYTES))
            begin
                ctr_next.received = ctr_reg.received + 32'd1;
                in_frame_next     = 1'b0;
                pos_next          = '0;
                last_ms_next      = '0;
                entry.status      = sbr_pkg::ST_ERROR;
                if (item.rx_byte != footer_reg)
                begin
                    ctr_next.malformed = ctr_reg.malformed + 32'd1;
                    if (item.rx_byte == header_reg)
                    begin
                        in_frame_next = 1'b1;
                        pos_next      = sbr_pkg::POS_W'(1);
                        last_ms_next  = item.time_ms;
                        write_header  = 1'b1;
                    end
                end
                else if (!sbr_pkg::UNPACK_OK)
                begin
                    ctr_next.malformed = ctr_reg.malformed + 32'd1;
                end
                else
                begin
                    ctr_next.valid   = ctr_reg.valid + 32'd1;
                    entry.status     = sbr_pkg::ST_READY;
                    entry.lost       = |(flags & lost_mask_reg);
                    entry.failsafe   = |(flags & failsafe_mask_reg);
                end
            end
        end

        entry.ctr = ctr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            last_ms_reg  <= '0;
            ctr_reg      <= '0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            last_ms_reg  <= last_ms_next;
            ctr_reg      <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && write_en)
        begin
            store_reg[pos_reg[sbr_pkg::STORE_AW-1:0]] <= item.rx_byte;
        end
        if (accept && write_header)
        begin
            store_reg[0] <= header_reg;
        end
    end

endmodule

FILE: rtl/sbr_fifo.sv
// Two-word queue between the front end and the unpacking back end.
module sbr_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  sbr_pkg::entry_t wr_data,
    input  logic            rd,
    output sbr_pkg::entry_t rd_data,
    output logic            full,
    output logic            empty
);

    sbr_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/sbr_back.sv
// Back end: unpack channel values one per cycle into the free result register.
module sbr_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  sbr_pkg::entry_t  q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output sbr_pkg::result_t result
);

    logic                          busy_reg;
    sbr_pkg::status_t              status_reg;
    logic                          lost_reg;
    logic                          fs_reg;
    sbr_pkg::ctr_t                 ctr_reg;
    logic [sbr_pkg::PAYLOAD_W-1:0] data_reg;
    logic [sbr_pkg::CH_W-1:0]      ch_reg;
    logic                          out_valid_reg;
    sbr_pkg::result_t              out_reg;

    logic out_free;
    logic emit;
    logic is_ready;
    logic is_last;

    assign out_free = !out_valid_reg || pop;
    assign emit     = busy_reg && out_free;
    assign q_pop    = !busy_reg && !q_empty;
    assign is_ready = status_reg == sbr_pkg::ST_READY;
    assign is_last  = !is_ready || (ch_reg == sbr_pkg::CH_W'(sbr_pkg::NUM_CHANNELS - 1));
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && is_last)
            begin
                busy_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= q_data.status;
            lost_reg   <= q_data.lost;
            fs_reg     <= q_data.failsafe;
            ctr_reg    <= q_data.ctr;
            data_reg   <= q_data.data;
            ch_reg     <= '0;
        end
        else if (emit)
        begin
            data_reg <= data_reg >> sbr_pkg::VAL_W;
            ch_reg   <= ch_reg + 1'b1;
        end

        if (emit)
        begin
            out_reg.status         <= status_reg;
            out_reg.chan_index     <= is_ready ? sbr_pkg::IDX_W'(ch_reg) : '0;
            out_reg.chan_value     <= is_ready ? data_reg[sbr_pkg::VAL_W-1:0] : '0;
            out_reg.lost           <= is_ready && lost_reg;
            out_reg.failsafe       <= is_ready && fs_reg;
            out_reg.last           <= is_last;
            out_reg.timeouts_seen  <= ctr_reg.timeouts;
            out_reg.malformed_seen <= ctr_reg.malformed;
            out_reg.received_seen  <= ctr_reg.received;
            out_reg.valid_seen     <= ctr_reg.valid;
        end
    end

endmodule

FILE: rtl/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver: front end, word queue and back end.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------
//  input   | in        | push / full      | item   (rx_byte, time_ms)
//  result  | out       | empty / pop      | result (status, channel, counters)
//  config  | in        | cfg_wr           | cfg_index, cfg_data
//
// Each byte is classified by the front end in the cycle it is accepted.
// A good frame gives 16 results from the back end, one per cycle unless stalled;
// every other byte gives one result via the queue, back end and result register.
// The two-word queue takes bytes while the back end unpacks; full rises only
// when both words wait. Reset clears control state and loads register defaults.
module sbus_frame_receiver
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  sbr_pkg::item_t              item,
    output logic                        empty,
    input  logic                        pop,
    output sbr_pkg::result_t            result,
    input  logic                        cfg_wr,
    input  logic [sbr_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [sbr_pkg::CFG_DW-1:0]  cfg_data
);

    sbr_pkg::entry_t front_entry;
    sbr_pkg::entry_t q_data;
    logic            accept;
    logic            q_pop;
    logic            q_empty;

    assign accept = push && !full;

    sbr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .entry     (front_entry)
    );

    sbr_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_data (front_entry),
        .rd      (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    sbr_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
